>>> src/tsoa_pkg.sv
// Shared types and codes for the two-stacks-in-one-array block.
package tsoa_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [2:0] CMD_PUSH_A = 3'd0;
  localparam logic [2:0] CMD_POP_A  = 3'd1;
  localparam logic [2:0] CMD_VIEW_A = 3'd2;
  localparam logic [2:0] CMD_PUSH_B = 3'd3;
  localparam logic [2:0] CMD_POP_B  = 3'd4;
  localparam logic [2:0] CMD_VIEW_B = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    word_t      push_value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    word_t      data;
    logic       last;
  } rsp_t;

endpackage

>>> src/two_stacks_one_array.sv
// Top level: two stacks sharing one word store.
// Stack A grows up from entry 0 and stack B grows down from entry DEPTH-1; a push
// fails with overflow once both together hold DEPTH words. One request is taken at a
// time. A push or a failed command goes straight to the response (SEND); a pop reads
// the store (LOAD) before SEND, and a view repeats LOAD and SEND once per word.
// Each SEND waits for rsp_ready. This follows from the single-port store with its
// registered read and the address adder that steps through the stack one word per read.
// Command codes 6 and 7 are dropped without a response.
module two_stacks_one_array
  import tsoa_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_en;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  word_t         mem_wdata;
  word_t         mem_rdata;

  tsoa_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .mem_en   (mem_en),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata)
  );

  tsoa_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

>>> src/tsoa_mem.sv
// Single-port word store with registered read data.
module tsoa_mem
  import tsoa_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  word_t         wdata,
  output word_t         rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

>>> src/tsoa_ctrl.sv
// Command sequencer: stack counts, shared address adder and response register.
module tsoa_ctrl
  import tsoa_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  req_t          req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rsp_t          rsp,
  output logic          mem_en,
  output logic          mem_we,
  output logic [AW-1:0] mem_addr,
  output word_t         mem_wdata,
  input  word_t         mem_rdata
);

  typedef enum logic [1:0] {IDLE, LOAD, SEND} state_t;

  state_t        state;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic [AW-1:0] addr;
  logic          side_b;
  logic          is_view;
  rsp_t          rsp_q;

  logic          accept;
  logic [CW:0]   sum_ab;
  logic          full;
  logic          a_empty;
  logic          b_empty;
  logic [CW-1:0] opx;
  logic [CW-1:0] opy;
  logic          sub;
  logic [CW-1:0] sum;
  logic          is_push;
  logic          rd_start;

  assign accept  = req_valid && (state == IDLE);
  assign sum_ab  = {1'b0, count_a} + {1'b0, count_b};
  assign full    = sum_ab >= (CW+1)'(DEPTH);
  assign a_empty = (count_a == '0);
  assign b_empty = (count_b == '0);
  assign is_push = (req.cmd == CMD_PUSH_A) || (req.cmd == CMD_PUSH_B);
  assign rd_start = ((req.cmd == CMD_POP_A) || (req.cmd == CMD_VIEW_A)) && !a_empty
                 || ((req.cmd == CMD_POP_B) || (req.cmd == CMD_VIEW_B)) && !b_empty;

  // shared address adder
  always_comb begin
    opx = '0;
    opy = '0;
    sub = 1'b0;
    if (state == IDLE) begin
      case (req.cmd) inside
        CMD_PUSH_A: begin
          opx = count_a;
        end
        CMD_POP_A, CMD_VIEW_A: begin
          opx = count_a;
          opy = CW'(1);
          sub = 1'b1;
        end
        CMD_PUSH_B: begin
          opx = CW'(DEPTH - 1);
          opy = count_b;
          sub = 1'b1;
        end
        CMD_POP_B, CMD_VIEW_B: begin
          opx = CW'(DEPTH);
          opy = count_b;
          sub = 1'b1;
        end
        default: ;
      endcase
    end else begin
      opx = CW'(addr);
      opy = CW'(1);
      sub = !side_b;
    end
  end

  assign sum       = sub ? opx - opy : opx + opy;
  assign mem_addr  = sum[AW-1:0];
  assign mem_we    = accept && is_push && !full;
  assign mem_en    = mem_we || (accept && rd_start)
                  || (state == SEND && rsp_ready && !rsp_q.last);
  assign mem_wdata = req.push_value;

  assign req_ready = (state == IDLE);
  assign rsp_valid = (state == SEND);
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      count_a <= '0;
      count_b <= '0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            case (req.cmd) inside
              CMD_PUSH_A, CMD_PUSH_B: begin
                rsp_q <= '{status: (full ? ST_OVERFLOW : ST_OK), data: '0, last: 1'b1};
                if (!full) begin
                  if (req.cmd == CMD_PUSH_A) begin
                    count_a <= count_a + CW'(1);
                  end else begin
                    count_b <= count_b + CW'(1);
                  end
                end
                state <= SEND;
              end
              CMD_POP_A, CMD_POP_B: begin
                if (rd_start) begin
                  if (req.cmd == CMD_POP_A) begin
                    count_a <= count_a - CW'(1);
                  end else begin
                    count_b <= count_b - CW'(1);
                  end
                  addr    <= mem_addr;
                  side_b  <= (req.cmd == CMD_POP_B);
                  is_view <= 1'b0;
                  state   <= LOAD;
                end else begin
                  rsp_q <= '{status: ST_UNDERFLOW, data: '0, last: 1'b1};
                  state <= SEND;
                end
              end
              CMD_VIEW_A, CMD_VIEW_B: begin
                if (rd_start) begin
                  addr    <= mem_addr;
                  side_b  <= (req.cmd == CMD_VIEW_B);
                  is_view <= 1'b1;
                  state   <= LOAD;
                end else begin
                  rsp_q <= '{status: ST_EMPTY, data: '0, last: 1'b1};
                  state <= SEND;
                end
              end
              default: ;
            endcase
          end
        end
        LOAD: begin
          rsp_q.status <= ST_OK;
          rsp_q.data   <= mem_rdata;
          rsp_q.last   <= !is_view || (side_b ? (addr == AW'(DEPTH - 1)) : (addr == '0));
          state        <= SEND;
        end
        SEND: begin
          if (rsp_ready) begin
            if (rsp_q.last) begin
              state <= IDLE;
            end else begin
              addr  <= mem_addr;
              state <= LOAD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> bench/two_stacks_one_array_tb.sv
// Self-checking testbench for two_stacks_one_array: random and directed push/pop/view traffic.
module two_stacks_one_array_tb;
  import tsoa_pkg::*;

  localparam int DEPTH = 16;
  localparam int ITEMS = 330;
  localparam int MAX_WAIT = 19;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  typedef struct {
    req_t req;
    int   gap;
    bit   drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  stim_t stim_q[$];
  rsp_t  due_results[$];

  word_t       mirror_store[DEPTH];
  int unsigned held_a;
  int unsigned held_b;

  stim_t       cur;
  bit          staged;
  int          wait_left;
  logic        req_acc;
  logic        rsp_acc;
  int          rsp_wait;
  int          rsp_hold;
  int          rsp_seen;
  bit          rsp_calm;
  int          errors;
  int unsigned cycle_count;
  rsp_t        want;

  two_stacks_one_array #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_t result_of(logic [1:0] st, word_t d, logic l);
    rsp_t r;
    r.status = st;
    r.data = d;
    r.last = l;
    return r;
  endfunction

  task automatic predict_stacks(input req_t r);
    case (r.cmd)
      CMD_PUSH_A: begin
        if (held_a + held_b >= DEPTH) begin
          due_results.push_back(result_of(ST_OVERFLOW, '0, 1'b1));
        end else begin
          mirror_store[held_a] = r.push_value;
          held_a++;
          due_results.push_back(result_of(ST_OK, '0, 1'b1));
        end
      end
      CMD_POP_A: begin
        if (held_a == 0) begin
          due_results.push_back(result_of(ST_UNDERFLOW, '0, 1'b1));
        end else begin
          held_a--;
          due_results.push_back(result_of(ST_OK, mirror_store[held_a], 1'b1));
        end
      end
      CMD_VIEW_A: begin
        if (held_a == 0) begin
          due_results.push_back(result_of(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = held_a; i > 0; i--)
            due_results.push_back(result_of(ST_OK, mirror_store[i-1], i == 1));
        end
      end
      CMD_PUSH_B: begin
        if (held_a + held_b >= DEPTH) begin
          due_results.push_back(result_of(ST_OVERFLOW, '0, 1'b1));
        end else begin
          held_b++;
          mirror_store[DEPTH-held_b] = r.push_value;
          due_results.push_back(result_of(ST_OK, '0, 1'b1));
        end
      end
      CMD_POP_B: begin
        if (held_b == 0) begin
          due_results.push_back(result_of(ST_UNDERFLOW, '0, 1'b1));
        end else begin
          due_results.push_back(result_of(ST_OK, mirror_store[DEPTH-held_b], 1'b1));
          held_b--;
        end
      end
      CMD_VIEW_B: begin
        if (held_b == 0) begin
          due_results.push_back(result_of(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = DEPTH - held_b; i < DEPTH; i++)
            due_results.push_back(result_of(ST_OK, mirror_store[i], i == DEPTH - 1));
        end
      end
      default: ;
    endcase
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return word_t'(32'h7FFF_FFFF);
      1: return word_t'(32'h8000_0000);
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic offer(input logic [2:0] c, input word_t v, input bit calm, input bit drain);
    stim_t s;
    s.req.cmd = c;
    s.req.push_value = v;
    s.gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
    s.drain = drain;
    stim_q.push_back(s);
  endtask

  // request side
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_acc) begin
      if (!staged && stim_q.size() > 0) begin
        cur = stim_q.pop_front();
        staged = 1'b1;
        wait_left = cur.gap;
      end
      if (staged && wait_left == 0 && !(cur.drain && due_results.size() != 0)) begin
        req <= cur.req;
        req_valid <= 1'b1;
        staged = 1'b0;
      end else begin
        if (staged && wait_left > 0)
          wait_left--;
        req_valid <= 1'b0;
      end
    end
  end

  // response side
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_wait = $urandom_range(0, MAX_WAIT);
    end else begin
      if (rsp_acc) begin
        rsp_seen++;
        if (rsp_seen == 40)
          rsp_hold = HOLD_CYCLES;
        if (rsp_seen % 64 == 0)
          rsp_calm = !rsp_calm;
        rsp_wait = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // sample handshakes, predict and check
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      req_acc <= 1'b0;
      rsp_acc <= 1'b0;
    end else begin
      req_acc <= req_valid && req_ready;
      rsp_acc <= rsp_valid && rsp_ready;
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected response: status %0d data %0d last %0b",
                 rsp.status, rsp.data, rsp.last);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, rsp.data);
            errors++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp.last);
            errors++;
          end
        end
      end
      if (req_valid && req_ready)
        predict_stacks(req);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("two_stacks_one_array regression: fail");
      $finish;
    end
  end

  initial begin
    int made;
    int n;
    int kind;
    int r;
    bit calm;
    bit first;
    logic [2:0] c;

    held_a = 0;
    held_b = 0;
    foreach (mirror_store[i]) mirror_store[i] = '0;

    // empty-stack cases, ignored codes, extreme words, fill to full, overflow
    offer(CMD_POP_A, pick_word(), 1'b0, 1'b0);
    offer(CMD_POP_B, pick_word(), 1'b0, 1'b0);
    offer(CMD_VIEW_A, pick_word(), 1'b0, 1'b0);
    offer(CMD_VIEW_B, pick_word(), 1'b0, 1'b0);
    offer(CMD_UNUSED_6, pick_word(), 1'b0, 1'b0);
    offer(CMD_UNUSED_7, pick_word(), 1'b0, 1'b0);
    offer(CMD_PUSH_A, word_t'(32'h7FFF_FFFF), 1'b0, 1'b0);
    offer(CMD_PUSH_B, word_t'(32'h8000_0000), 1'b0, 1'b0);
    offer(CMD_PUSH_A, word_t'(32'h8000_0000), 1'b0, 1'b0);
    offer(CMD_PUSH_B, word_t'(32'h7FFF_FFFF), 1'b0, 1'b0);
    for (int j = 0; j < DEPTH - 4; j++)
      offer((j % 2) ? CMD_PUSH_B : CMD_PUSH_A, word_t'($urandom), 1'b1, 1'b0);
    offer(CMD_PUSH_A, pick_word(), 1'b0, 1'b0);
    offer(CMD_PUSH_B, pick_word(), 1'b0, 1'b0);
    offer(CMD_VIEW_A, pick_word(), 1'b0, 1'b0);
    offer(CMD_VIEW_B, pick_word(), 1'b0, 1'b0);

    made = 0;
    first = 1'b1;
    while (made < ITEMS) begin
      kind = $urandom_range(0, 7);
      n = $urandom_range(4, 20);
      calm = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < n; j++) begin
        case (kind)
          0: c = CMD_PUSH_A;
          1: c = CMD_PUSH_B;
          2: c = $urandom_range(0, 1) ? CMD_PUSH_A : CMD_PUSH_B;
          3: c = CMD_POP_A;
          4: c = CMD_POP_B;
          default: begin
            r = $urandom_range(0, 31);
            if (r < 8) c = CMD_PUSH_A;
            else if (r < 16) c = CMD_PUSH_B;
            else if (r < 21) c = CMD_POP_A;
            else if (r < 26) c = CMD_POP_B;
            else if (r < 28) c = CMD_VIEW_A;
            else if (r < 30) c = CMD_VIEW_B;
            else if (r < 31) c = CMD_UNUSED_6;
            else c = CMD_UNUSED_7;
          end
        endcase
        offer(c, pick_word(), calm, j == 0 && (first || $urandom_range(0, 2) == 0));
        first = 1'b0;
        if (c != CMD_UNUSED_6 && c != CMD_UNUSED_7)
          made++;
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || staged || req_valid)
      @(posedge clk);
    while (due_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (due_results.size() != 0) begin
      $error("%0d responses never arrived", due_results.size());
      errors++;
    end
    if (errors == 0)
      $display("two_stacks_one_array regression: pass");
    else
      $display("two_stacks_one_array regression: fail");
    $finish;
  end

endmodule

>>> files.f
src/tsoa_pkg.sv
src/tsoa_mem.sv
src/tsoa_ctrl.sv
src/two_stacks_one_array.sv
bench/two_stacks_one_array_tb.sv
